FILE: hdl/mts_pkg.sv
// Package for the melody tone sequencer: op and melody codes, register map,
// note record type and the constant note ROM lookup.
// No dependencies.
`default_nettype none

package mts_pkg;

   // Input op codes
   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_PLAY = 2'd1;
   localparam logic [1:0] OP_STOP = 2'd2;

   // Melody codes
   localparam logic [1:0] SND_BEEP  = 2'd0;
   localparam logic [1:0] SND_ALERT = 2'd1;
   localparam logic [1:0] SND_HAPPY = 2'd2;

   // Field widths
   localparam int unsigned TONE_W = 12;
   localparam int unsigned MS_W   = 8;
   localparam int unsigned STEP_W = 3;

   // Register map
   localparam int unsigned     CSR_ADDR_W          = 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SOUND_ENABLE = 2'd0;

   // One note of a melody: frequency (0 is a rest) and length in ms
   typedef struct packed {
      logic [TONE_W-1:0] hz;
      logic [MS_W-1:0]   ms;
   } note_type;

   // Number of notes in a melody; 0 for an unknown code
   function automatic logic [STEP_W-1:0] note_count(input logic [1:0] kind);
      logic [STEP_W-1:0] cnt;
      case (kind)
         SND_BEEP:  cnt = 3'd1;
         SND_ALERT: cnt = 3'd7;
         SND_HAPPY: cnt = 3'd7;
         default:   cnt = 3'd0;
      endcase
      return cnt;
   endfunction

   // Note ROM: alert and happy alternate tones with short rests
   function automatic note_type note_lookup(input logic [1:0] kind,
                                            input logic [STEP_W-1:0] step);
      note_type n;
      n = '{hz: 12'd0, ms: 8'd0};
      case (kind)
         SND_BEEP: begin
            if (step == 3'd0) n = '{hz: 12'd2400, ms: 8'd45};
         end
         SND_ALERT: begin
            case (step)
               3'd0:    n = '{hz: 12'd1800, ms: 8'd120};
               3'd1:    n = '{hz: 12'd0,    ms: 8'd60};
               3'd2:    n = '{hz: 12'd1100, ms: 8'd140};
               3'd3:    n = '{hz: 12'd0,    ms: 8'd60};
               3'd4:    n = '{hz: 12'd1800, ms: 8'd120};
               3'd5:    n = '{hz: 12'd0,    ms: 8'd60};
               3'd6:    n = '{hz: 12'd1100, ms: 8'd180};
               default: n = '{hz: 12'd0,    ms: 8'd0};
            endcase
         end
         SND_HAPPY: begin
            case (step)
               3'd0:    n = '{hz: 12'd1568, ms: 8'd100};
               3'd1:    n = '{hz: 12'd0,    ms: 8'd25};
               3'd2:    n = '{hz: 12'd1976, ms: 8'd100};
               3'd3:    n = '{hz: 12'd0,    ms: 8'd25};
               3'd4:    n = '{hz: 12'd2349, ms: 8'd100};
               3'd5:    n = '{hz: 12'd0,    ms: 8'd25};
               3'd6:    n = '{hz: 12'd3136, ms: 8'd240};
               default: n = '{hz: 12'd0,    ms: 8'd0};
            endcase
         end
         default: n = '{hz: 12'd0, ms: 8'd0};
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/mts_req_if.sv
// Request channel of the melody tone sequencer: valid/ready plus op and melody.
// Depends on mts_pkg.
`default_nettype none

interface mts_req_if
   import mts_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [1:0] sound_id;

   modport source (output valid, output op, output sound_id, input ready);
   modport sink   (input valid, input op, input sound_id, output ready);
endinterface

`default_nettype wire

FILE: hdl/mts_rsp_if.sv
// Response channel of the melody tone sequencer: valid/ready plus tone state.
// Depends on mts_pkg.
`default_nettype none

interface mts_rsp_if
   import mts_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [TONE_W-1:0] tone_hz;
   logic              busy_res;
   logic [1:0]        sound_now;

   modport source (output valid, output tone_hz, output busy_res, output sound_now,
                   input ready);
   modport sink   (input valid, input tone_hz, input busy_res, input sound_now,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/melody_tone_sequencer.sv
// Melody tone sequencer top level: player state, note ROM lookup, APB enable
// register and a two-beat response buffer. Depends on mts_pkg, mts_req_if, mts_rsp_if.
//
// Usage:
//  - req_ch carries one beat per command: op = tick (1 ms), play or stop,
//    and sound_id selecting beep, alert or happy for play.
//  - Every accepted request beat gives exactly one rsp_ch beat with the tone
//    now driven (0 is silence), the busy flag and the melody started last.
//  - The player state and the response beat are both registered at the accepting
//    edge; the beat goes to the output register, or to the skid register if held.
//  - One request is taken per cycle while req_ch.ready is high; the state update
//    is combinational: ROM lookups, 8-bit and 3-bit increments and compares.
//  - When the receiver stalls, a second response is parked in a skid register,
//    so req_ch.ready drops only once two responses wait.
//  - csr_* is an APB-style port holding sound_enable at address 0 (reset 1);
//    writing 0 silences the buzzer and idles the player. Writes are meant to be
//    made only while no request is in flight.
//  - Reset (synchronous, active high) idles the player, sets silence, melody
//    beep, enables sound and empties the response buffer.
`default_nettype none

module melody_tone_sequencer
   import mts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   mts_req_if.sink                    req_ch,
   mts_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready
);

   // Player state
   logic              enable_ff,  enable_in;
   logic              active_ff,  active_in;
   logic [1:0]        kind_ff,    kind_in;
   logic [STEP_W-1:0] step_ff,    step_in;
   logic [MS_W-1:0]   elapsed_ff, elapsed_in;
   logic [TONE_W-1:0] tone_ff,    tone_in;

   // Response buffer: output register plus skid register
   logic              out_valid_ff,  out_valid_in;
   logic [TONE_W-1:0] out_tone_ff,   out_tone_in;
   logic              out_busy_ff,   out_busy_in;
   logic [1:0]        out_kind_ff,   out_kind_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [TONE_W-1:0] skid_tone_ff,  skid_tone_in;
   logic              skid_busy_ff,  skid_busy_in;
   logic [1:0]        skid_kind_ff,  skid_kind_in;

   logic              accept;
   logic              pop;
   logic              csr_write;
   note_type          cur_note;
   note_type          next_note;
   note_type          first_note;
   logic [STEP_W-1:0] cur_count;
   logic [STEP_W-1:0] step_inc;
   logic [MS_W-1:0]   elapsed_inc;

   assign req_ch.ready = !skid_valid_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = out_valid_ff && rsp_ch.ready;
   assign csr_write    = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // APB read side
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr == ADDR_SOUND_ENABLE) csr_prdata = {31'd0, enable_ff};
   end

   // ROM lookups for the current and following note, and a requested melody
   assign cur_count   = note_count(kind_ff);
   assign step_inc    = step_ff + 3'd1;
   assign elapsed_inc = elapsed_ff + 8'd1;
   assign cur_note    = note_lookup(kind_ff, step_ff);
   assign next_note   = note_lookup(kind_ff, step_inc);
   assign first_note  = note_lookup(req_ch.sound_id, 3'd0);

   // Player next state
   always_comb begin
      enable_in  = enable_ff;
      active_in  = active_ff;
      kind_in    = kind_ff;
      step_in    = step_ff;
      elapsed_in = elapsed_ff;
      tone_in    = tone_ff;

      if (csr_write && csr_paddr == ADDR_SOUND_ENABLE) begin
         enable_in = csr_pwdata[0];
         if (!csr_pwdata[0]) begin
            active_in  = 1'b0;
            step_in    = '0;
            elapsed_in = '0;
            tone_in    = '0;
         end
      end else if (accept) begin
         unique case (req_ch.op)
            OP_TICK: begin
               if (active_ff) begin
                  if (step_ff >= cur_count) begin
                     active_in  = 1'b0;
                     step_in    = '0;
                     elapsed_in = '0;
                     tone_in    = '0;
                  end else if (elapsed_inc >= cur_note.ms) begin
                     // note done: advance or finish the melody
                     if (step_inc >= cur_count) begin
                        active_in  = 1'b0;
                        step_in    = '0;
                        elapsed_in = '0;
                        tone_in    = '0;
                     end else begin
                        step_in    = step_inc;
                        elapsed_in = '0;
                        tone_in    = next_note.hz;
                     end
                  end else begin
                     elapsed_in = elapsed_inc;
                  end
               end
            end
            OP_PLAY: begin
               // beep never interrupts alert or happy; unknown melody ignored
               if (enable_ff && note_count(req_ch.sound_id) != 3'd0 &&
                   !(req_ch.sound_id == SND_BEEP && active_ff && kind_ff != SND_BEEP)) begin
                  kind_in    = req_ch.sound_id;
                  step_in    = '0;
                  elapsed_in = '0;
                  active_in  = 1'b1;
                  tone_in    = first_note.hz;
               end
            end
            OP_STOP: begin
               active_in  = 1'b0;
               step_in    = '0;
               elapsed_in = '0;
               tone_in    = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Response buffer next state
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_tone_in   = out_tone_ff;
      out_busy_in   = out_busy_ff;
      out_kind_in   = out_kind_ff;
      skid_valid_in = skid_valid_ff;
      skid_tone_in  = skid_tone_ff;
      skid_busy_in  = skid_busy_ff;
      skid_kind_in  = skid_kind_ff;

      if (skid_valid_ff) begin
         if (pop) begin
            out_tone_in   = skid_tone_ff;
            out_busy_in   = skid_busy_ff;
            out_kind_in   = skid_kind_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_tone_in  = tone_in;
            out_busy_in  = active_in;
            out_kind_in  = kind_in;
         end else begin
            skid_valid_in = 1'b1;
            skid_tone_in  = tone_in;
            skid_busy_in  = active_in;
            skid_kind_in  = kind_in;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b1;
         active_ff     <= 1'b0;
         kind_ff       <= SND_BEEP;
         step_ff       <= '0;
         elapsed_ff    <= '0;
         tone_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         enable_ff     <= enable_in;
         active_ff     <= active_in;
         kind_ff       <= kind_in;
         step_ff       <= step_in;
         elapsed_ff    <= elapsed_in;
         tone_ff       <= tone_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      out_tone_ff  <= out_tone_in;
      out_busy_ff  <= out_busy_in;
      out_kind_ff  <= out_kind_in;
      skid_tone_ff <= skid_tone_in;
      skid_busy_ff <= skid_busy_in;
      skid_kind_ff <= skid_kind_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.tone_hz   = out_tone_ff;
   assign rsp_ch.busy_res  = out_busy_ff;
   assign rsp_ch.sound_now = out_kind_ff;

   // Checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a beat while output register is empty");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> tone_ff == '0)
      else $error("tone driven while player idle");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> step_ff < note_count(kind_ff))
      else $error("note step beyond end of melody");

   a_disable_stops: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_paddr == ADDR_SOUND_ENABLE && !csr_pwdata[0]) |=>
         (!active_ff && !enable_ff))
      else $error("clearing sound_enable did not stop playback");

endmodule

`default_nettype wire

FILE: sim/mts_tone_checker.sv
// Checker for the melody tone sequencer: watches request, response and CSR traffic,
// keeps its own copy of the player and compares every response beat.
// Depends on mts_pkg, mts_req_if and mts_rsp_if.
`timescale 1ns / 100ps

module mts_tone_checker
   import mts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   mts_req_if                         req_mon,
   mts_rsp_if                         rsp_mon,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic                  csr_pready,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   input  wire logic [31:0]           csr_prdata,
   output int                         error_count,
   output int                         states_due
);

   // Buzzer state carried by one response beat
   typedef struct packed {
      logic [TONE_W-1:0] tone;
      logic              busy;
      logic [1:0]        kind;
   } buzzer_state_type;

   // Melody table: tones (0 is a rest), note lengths in ms, note counts
   localparam logic [0:2][0:6][TONE_W-1:0] TUNE_HZ = '{
      '{12'd2400, 12'd0, 12'd0,    12'd0, 12'd0,    12'd0, 12'd0},
      '{12'd1800, 12'd0, 12'd1100, 12'd0, 12'd1800, 12'd0, 12'd1100},
      '{12'd1568, 12'd0, 12'd1976, 12'd0, 12'd2349, 12'd0, 12'd3136}};
   localparam logic [0:2][0:6][MS_W-1:0] TUNE_MS = '{
      '{8'd45,  8'd0,  8'd0,   8'd0,  8'd0,   8'd0,  8'd0},
      '{8'd120, 8'd60, 8'd140, 8'd60, 8'd120, 8'd60, 8'd180},
      '{8'd100, 8'd25, 8'd100, 8'd25, 8'd100, 8'd25, 8'd240}};
   localparam logic [0:2][STEP_W-1:0] TUNE_LEN = '{3'd1, 3'd7, 3'd7};

   // Player copy
   logic              sound_on;
   logic              playing;
   logic [1:0]        melody;
   logic [STEP_W-1:0] note_idx;
   logic [MS_W-1:0]   note_time;
   logic [TONE_W-1:0] tone;

   buzzer_state_type due_states [$];
   buzzer_state_type want;
   int               mismatches = 0;

   function automatic void mute_player();
      tone      = '0;
      playing   = 1'b0;
      note_idx  = '0;
      note_time = '0;
   endfunction

   // Apply one request beat to the player copy
   function automatic void predict_beat(input logic [1:0] op, input logic [1:0] id);
      case (op)
         OP_TICK: begin
            if (playing) begin
               if (melody > SND_HAPPY || note_idx >= TUNE_LEN[melody]) begin
                  mute_player();
               end else begin
                  note_time = note_time + 1'b1;
                  if (note_time >= TUNE_MS[melody][note_idx]) begin
                     note_time = '0;
                     note_idx  = note_idx + 1'b1;
                     if (note_idx >= TUNE_LEN[melody]) mute_player();
                     else tone = TUNE_HZ[melody][note_idx];
                  end
               end
            end
         end
         OP_PLAY: begin
            // beep never cuts into alert or happy; unknown melody is dropped
            if (sound_on && id <= SND_HAPPY &&
                !(id == SND_BEEP && playing && melody != SND_BEEP)) begin
               melody    = id;
               note_idx  = '0;
               note_time = '0;
               playing   = 1'b1;
               tone      = TUNE_HZ[id][0];
            end
         end
         OP_STOP: mute_player();
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         sound_on = 1'b1;
         melody   = SND_BEEP;
         mute_player();
         due_states.delete();
      end else begin
         // response beat against the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_states.size() == 0) begin
               mismatches++;
               $display("%0t: response beat with none expected: tone %0d busy %0d sound %0d",
                        $time, rsp_mon.tone_hz, rsp_mon.busy_res, rsp_mon.sound_now);
            end else begin
               want = due_states.pop_front();
               if (rsp_mon.tone_hz !== want.tone) begin
                  mismatches++;
                  $display("%0t: tone_hz expected %0d, got %0d",
                           $time, want.tone, rsp_mon.tone_hz);
               end
               if (rsp_mon.busy_res !== want.busy) begin
                  mismatches++;
                  $display("%0t: busy_res expected %0d, got %0d",
                           $time, want.busy, rsp_mon.busy_res);
               end
               if (rsp_mon.sound_now !== want.kind) begin
                  mismatches++;
                  $display("%0t: sound_now expected %0d, got %0d",
                           $time, want.kind, rsp_mon.sound_now);
               end
            end
         end

         // CSR access phase
         if (csr_psel && csr_penable && csr_pready && csr_paddr == ADDR_SOUND_ENABLE) begin
            if (csr_pwrite) begin
               sound_on = csr_pwdata[0];
               if (!sound_on) mute_player();
            end else if (csr_prdata !== {31'b0, sound_on}) begin
               mismatches++;
               $display("%0t: sound_enable read expected %0h, got %0h",
                        $time, {31'b0, sound_on}, csr_prdata);
            end
         end

         // request beat
         if (req_mon.valid && req_mon.ready) begin
            predict_beat(req_mon.op, req_mon.sound_id);
            due_states.push_back('{tone: tone, busy: playing, kind: melody});
         end
      end
      error_count <= mismatches;
      states_due  <= due_states.size();
   end

endmodule

FILE: sim/tb_melody_tone_sequencer.sv
// Testbench top for the melody tone sequencer: clock, reset, request stimulus,
// response back-pressure and CSR writes; checking lives in mts_tone_checker.
// Depends on mts_pkg, mts_req_if, mts_rsp_if, mts_tone_checker and the RTL.
`timescale 1ns / 100ps

module tb_melody_tone_sequencer;
   import mts_pkg::*;

   // codes the package leaves out
   localparam logic [1:0]            OP_UNUSED     = 2'd3;
   localparam logic [1:0]            SND_NONE      = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = '1;
   localparam int                    LONG_HOLD     = 80;

   typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   mts_req_if req_ch ();
   mts_rsp_if rsp_ch ();

   int          tone_errors;
   int          tones_pending;
   int          hold_asks   = 0;
   int          hold_served = 0;
   int          hold_left;
   int          rx_left;
   rx_mode_type rx_mode;
   int          burst_left  = 0;
   int          items_sent  = 0;
   bit          steady      = 1'b0;

   melody_tone_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mts_tone_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .error_count (tone_errors),
      .states_due  (tones_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response back-pressure: random modes, plus long holds on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         rx_left      <= 0;
         rx_mode      <= RX_OPEN;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (hold_served != hold_asks) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= LONG_HOLD;
         hold_served  <= hold_served + 1;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            rx_left <= $urandom_range(16, 160);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_OPEN:   rsp_ch.ready <= 1'b1;
            RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            default:   rsp_ch.ready <= rx_left[1];
         endcase
      end
   end

   // Offer one request beat; bursts of random length with random gaps
   task automatic offer(input logic [1:0] op, input logic [1:0] id);
      int gap;
      if (burst_left == 0) begin
         gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.sound_id <= id;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Sender pauses until every predicted response has arrived
   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (tones_pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Write sound_enable and read it back
   task automatic set_enable(input logic [31:0] data);
      csr_access(1'b1, ADDR_SOUND_ENABLE, data);
      csr_access(1'b0, ADDR_SOUND_ENABLE, '0);
   endtask

   // Fill the block: receiver holds off while the sender keeps going
   task automatic squeeze();
      steady = 1'b1;
      hold_asks <= hold_asks + 1;
      offer(OP_PLAY, SND_ALERT);
      repeat (40) offer(OP_TICK, 2'($urandom_range(0, 3)));
      steady = 1'b0;
   endtask

   task automatic offer_noise();
      offer(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
   endtask

   // Start a melody, then tick through it (often to the end) with rare noise
   task automatic play_segment();
      logic [1:0] id;
      int         pick;
      int         full;
      int         ticks;
      if ($urandom_range(0, 4) == 0) drain();
      pick = $urandom_range(0, 15);
      if (pick < 5) id = SND_BEEP;
      else if (pick < 10) id = SND_ALERT;
      else if (pick < 15) id = SND_HAPPY;
      else id = SND_NONE;
      case (id)
         SND_BEEP:  full = 48;
         SND_ALERT: full = 742;
         SND_HAPPY: full = 617;
         default:   full = 8;
      endcase
      offer(OP_PLAY, id);
      ticks = ($urandom_range(0, 2) == 0) ? full + $urandom_range(0, 5)
                                           : $urandom_range(1, full);
      repeat (ticks) begin
         case ($urandom_range(0, 99))
            0:       offer(OP_STOP, 2'($urandom_range(0, 3)));
            1:       offer(OP_UNUSED, 2'($urandom_range(0, 3)));
            2, 3:    offer(OP_PLAY, 2'($urandom_range(0, 3)));
            default: offer(OP_TICK, 2'($urandom_range(0, 3)));
         endcase
      end
   endtask

   // Run limit
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus
   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.op       <= OP_TICK;
      req_ch.sound_id <= SND_BEEP;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= ADDR_SOUND_ENABLE;
      csr_pwdata      <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, ADDR_SOUND_ENABLE, '0);

      // directed: idle cases, restarts, beep over other melodies, stop
      offer(OP_TICK, SND_NONE);
      offer(OP_STOP, SND_HAPPY);
      offer(OP_UNUSED, SND_NONE);
      offer(OP_PLAY, SND_NONE);
      offer(OP_PLAY, SND_BEEP);
      offer(OP_TICK, SND_BEEP);
      offer(OP_PLAY, SND_BEEP);
      offer(OP_PLAY, SND_ALERT);
      offer(OP_PLAY, SND_BEEP);
      offer(OP_TICK, SND_ALERT);
      offer(OP_PLAY, SND_HAPPY);
      offer(OP_TICK, SND_HAPPY);
      offer(OP_PLAY, SND_ALERT);
      offer(OP_STOP, SND_NONE);
      offer(OP_TICK, SND_NONE);
      offer(OP_PLAY, SND_HAPPY);
      offer(OP_UNUSED, SND_ALERT);
      offer(OP_PLAY, SND_BEEP);
      offer(OP_STOP, SND_BEEP);
      drain();

      // enabled, random melodies
      squeeze();
      while (items_sent < 800) play_segment();
      offer(OP_PLAY, SND_HAPPY);
      repeat (5) offer(OP_TICK, SND_BEEP);
      drain();

      // disabling mid-melody stops it; plays are ignored while disabled
      set_enable(32'h0000_0000);
      repeat (150) offer_noise();
      drain();
      set_enable(32'hFFFF_FFFF);
      csr_access(1'b1, ADDR_UNMAPPED, '0);
      csr_access(1'b0, ADDR_SOUND_ENABLE, '0);

      // enabled again
      squeeze();
      while (items_sent < 1900) play_segment();
      drain();
      set_enable(32'hFFFF_FFFE);
      repeat (20) offer_noise();
      drain();
      set_enable(32'($urandom()) | 32'h1);
      offer(OP_PLAY, SND_BEEP);
      repeat (50) offer(OP_TICK, SND_BEEP);
      drain();

      repeat (10) @(posedge clock);
      if (tone_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/mts_pkg.sv
hdl/mts_req_if.sv
hdl/mts_rsp_if.sv
hdl/melody_tone_sequencer.sv
sim/mts_tone_checker.sv
sim/tb_melody_tone_sequencer.sv
